// ===== design/cfperm_pkg.sv =====
// Shared constants and control types for the orbit-minimum canonical form block.
// Depends on nothing; every other design file but cfperm_ram refers to it by scoped names.
package cfperm_pkg;

  localparam int EDGES     = 32;
  localparam int MAX_PERMS = 512;

  localparam int SET_W   = 32;
  localparam int ENTRY_W = 5;
  localparam int SLOT_IN_W = 9;
  localparam int CFG_W   = 10;

  localparam int LANES  = (EDGES < SET_W) ? EDGES : SET_W;
  localparam int SLOT_W = (MAX_PERMS > 1) ? $clog2(MAX_PERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_PERMS + 1);

  localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << LANES) - 64'd1);

  typedef struct packed {
    logic load;
    logic start;
    logic rd_en;
    logic cmp_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cfg_zero;
    logic last;
  } sts_t;

endpackage

// ===== design/cfperm_if.sv =====
// Valid/ready channel interfaces for query/load requests and results.
// Depends on cfperm_pkg for field widths.
interface cfperm_req_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [cfperm_pkg::SLOT_IN_W-1:0] perm_slot;
  logic [cfperm_pkg::ENTRY_W-1:0]   dest_edge;
  logic [cfperm_pkg::ENTRY_W-1:0]   source_edge;
  logic [cfperm_pkg::SET_W-1:0]     edge_set;

  modport source (output valid, mode, perm_slot, dest_edge, source_edge, edge_set,
                  input ready);
  modport sink (input valid, mode, perm_slot, dest_edge, source_edge, edge_set,
                output ready);
endinterface

interface cfperm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cfperm_pkg::SET_W-1:0] canonical_set;

  modport source (output valid, canonical_set, input ready);
  modport sink (input valid, canonical_set, output ready);
endinterface

// ===== design/cfperm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module cfperm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cfperm_dp.sv =====
// Datapath: permutation table banks, cursor, image builder and running minimum.
// Depends on cfperm_pkg and cfperm_ram; driven by cfperm_ctrl through cmd_t.
module cfperm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cfperm_pkg::CFG_W-1:0]      cfg_data,
  input  logic [cfperm_pkg::SLOT_IN_W-1:0]  perm_slot,
  input  logic [cfperm_pkg::ENTRY_W-1:0]    dest_edge,
  input  logic [cfperm_pkg::ENTRY_W-1:0]    source_edge,
  input  logic [cfperm_pkg::SET_W-1:0]      edge_set,
  input  cfperm_pkg::cmd_t                  cmd,
  output cfperm_pkg::sts_t                  sts,
  output logic [cfperm_pkg::SET_W-1:0]      canonical_set
);

  logic [cfperm_pkg::CFG_W-1:0]   active_perms;
  logic [cfperm_pkg::CNT_W-1:0]   count;
  logic [cfperm_pkg::CNT_W-1:0]   count_next;
  logic [cfperm_pkg::CNT_W-1:0]   cursor;
  logic [cfperm_pkg::SET_W-1:0]   set_reg;
  logic [cfperm_pkg::SET_W-1:0]   best;
  logic [cfperm_pkg::SET_W-1:0]   image;
  logic [cfperm_pkg::ENTRY_W-1:0] rows [cfperm_pkg::LANES];
  logic                           slot_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_perms <= '0;
    end else if (cfg_we) begin
      active_perms <= cfg_data;
    end
  end

  always_comb begin
    if (32'(active_perms) > 32'(cfperm_pkg::MAX_PERMS)) begin
      count_next = cfperm_pkg::CNT_W'(cfperm_pkg::MAX_PERMS);
    end else begin
      count_next = cfperm_pkg::CNT_W'(active_perms);
    end
  end

  assign slot_ok = 32'(perm_slot) < 32'(cfperm_pkg::MAX_PERMS);

  for (genvar e = 0; e < cfperm_pkg::LANES; e++) begin : g_bank
    cfperm_ram #(
      .WIDTH (cfperm_pkg::ENTRY_W),
      .DEPTH (cfperm_pkg::MAX_PERMS)
    ) u_bank (
      .clk   (clk),
      .we    (cmd.load && slot_ok && (32'(dest_edge) == e)),
      .waddr (cfperm_pkg::SLOT_W'(perm_slot)),
      .wdata (source_edge),
      .re    (cmd.rd_en),
      .raddr (cursor[cfperm_pkg::SLOT_W-1:0]),
      .rdata (rows[e])
    );
  end

  always_comb begin
    image = '0;
    for (int e = 0; e < cfperm_pkg::LANES; e++) begin
      if (32'(rows[e]) < 32'(cfperm_pkg::LANES)) begin
        image[e] = set_reg[rows[e]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      count  <= '0;
    end else if (cmd.start) begin
      cursor <= '0;
      count  <= count_next;
    end else if (cmd.rd_en) begin
      cursor <= cursor + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      set_reg <= edge_set & cfperm_pkg::SET_MASK;
      best    <= edge_set & cfperm_pkg::SET_MASK;
    end else if (cmd.cmp_en && (image < best)) begin
      best <= image;
    end
    if (cmd.out_load) begin
      canonical_set <= best;
    end
  end

  assign sts.cfg_zero = (count_next == '0);
  assign sts.last     = (cursor == count - 1'b1);

endmodule

// ===== design/cfperm_ctrl.sv =====
// Controller: request handshake, query sequencing and result register valid.
// Depends on cfperm_pkg; commands cfperm_dp through cmd_t and reads sts_t.
module cfperm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cfperm_pkg::sts_t sts,
  output cfperm_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rd_pend;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.start    = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.cmp_en   = rd_pend;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && !in_mode) begin
          cmd.load = 1'b1;
        end else if (accept) begin
          cmd.start  = 1'b1;
          state_next = sts.cfg_zero ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        cmd.rd_en = 1'b1;
        if (sts.last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= cmd.rd_en;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/canonical_form_under_permutations_core.sv =====
// Top level of the orbit-minimum canonical form block: controller plus datapath.
// Depends on cfperm_pkg, cfperm_if, cfperm_ctrl and cfperm_dp.
//
//   channel  direction  handshake      payload
//   query    in         valid/ready    mode, perm_slot, dest_edge, source_edge, edge_set
//   result   out        valid/ready    canonical_set
//   cfg      in         cfg_we         cfg_data (active_permutations)
//
// A load request writes one table entry when accepted. A query sweeps N rows,
// N = min(active_permutations, MAX_PERMS), one table row read per cycle from
// the bank-per-edge permutation RAMs, then registers its result; N = 0 skips
// the sweep. Synchronous reset clears control and the cfg register; the table
// holds nothing until loaded. A finished query waits in the controller until an
// earlier result is taken, and requests stall meanwhile, loads as well.
module canonical_form_under_permutations_core (
  input  logic                         clk,
  input  logic                         rst,
  cfperm_req_if.sink                   query,
  cfperm_rsp_if.source                 result,
  input  logic                         cfg_we,
  input  logic [cfperm_pkg::CFG_W-1:0] cfg_data
);

  cfperm_pkg::cmd_t cmd;
  cfperm_pkg::sts_t sts;

  cfperm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_mode   (query.mode),
    .in_ready  (query.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfperm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .perm_slot     (query.perm_slot),
    .dest_edge     (query.dest_edge),
    .source_edge   (query.source_edge),
    .edge_set      (query.edge_set),
    .cmd           (cmd),
    .sts           (sts),
    .canonical_set (result.canonical_set)
  );

  a_start_on_query: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (query.valid && query.ready && query.mode))
    else $error("query start without accepted query request");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result.valid && !result.ready))
    else $error("result register overwritten while pending");

  a_busy_while_reading: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || cmd.cmp_en) |-> !query.ready)
    else $error("request accepted during table sweep");

  a_load_not_during_query: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.load)
    else $error("table load right after query start");

endmodule
